@@ sv/scratchpad_crc_temperature_check_assert.svh @@
// ----------------------------------------------------------------------------
// Scratchpad CRC temperature check assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SCRATCHPAD_CRC_TEMPERATURE_CHECK_ASSERT_SVH
`define SCRATCHPAD_CRC_TEMPERATURE_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SCTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SCTC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/sctc_pkg.sv @@
// ----------------------------------------------------------------------------
// Scratchpad CRC temperature check package
// Shared widths, result types and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package sctc_pkg;

	localparam int BYTE_W = 8;
	localparam int TEMP_W = 12;
	localparam int POS_W  = 4;

	// Reflected form of x^8+x^5+x^4+1.
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic              crc_ok;
		logic [BYTE_W-1:0] crc_remainder;
	} sctc_res_t;

	typedef struct packed {
		logic      last;
		sctc_res_t res;
	} sctc_core_out_t;

	// One byte through the CRC, one bit per step, least significant first.
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ sv/sctc_byte_if.sv @@
// ----------------------------------------------------------------------------
// Scratchpad byte channel
// Valid/ready channel carrying one scratchpad byte per request.
// ----------------------------------------------------------------------------
interface sctc_byte_if;
	import sctc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

@@ sv/sctc_result_if.sv @@
// ----------------------------------------------------------------------------
// Temperature result channel
// Valid/ready channel carrying one frame result per request.
// ----------------------------------------------------------------------------
interface sctc_result_if;
	import sctc_pkg::*;

	logic              valid;
	logic              ready;
	logic [TEMP_W-1:0] temperature;
	logic              crc_ok;
	logic [BYTE_W-1:0] crc_remainder;

	modport source (output valid, output temperature, output crc_ok, output crc_remainder,
		input ready);
	modport sink (input valid, input temperature, input crc_ok, input crc_remainder,
		output ready);
endinterface

@@ sv/sctc_frame_core.sv @@
// ----------------------------------------------------------------------------
// Scratchpad frame core
// Running CRC, byte position, captured bytes and held temperature.
// ----------------------------------------------------------------------------
module sctc_frame_core #(
	parameter int FRAME_BYTES = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [sctc_pkg::BYTE_W-1:0]   data_byte,
	output sctc_pkg::sctc_core_out_t      status
);
	import sctc_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	logic [BYTE_W-1:0] crc_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] low_q;
	logic [BYTE_W-1:0] high_q;
	logic [TEMP_W-1:0] temp_q;

	logic [BYTE_W-1:0]   crc_next;
	logic                last;
	logic                ok;
	logic [2*BYTE_W-1:0] word;
	logic [TEMP_W-1:0]   temp_next;

	always_comb begin
		crc_next  = crc8_update(crc_q, data_byte);
		last      = (pos_q >= LAST_POS);
		ok        = (crc_next == '0);
		word      = {high_q, low_q};
		temp_next = ok ? word[2*BYTE_W-1:2*BYTE_W-TEMP_W] : temp_q;
	end

	assign status.last              = last;
	assign status.res.temperature   = temp_next;
	assign status.res.crc_ok        = ok;
	assign status.res.crc_remainder = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			pos_q  <= '0;
			low_q  <= '0;
			high_q <= '0;
			temp_q <= '0;
		end else if (fire) begin
			if (pos_q == POS_W'(0)) begin
				low_q <= data_byte;
			end
			if (pos_q == POS_W'(1)) begin
				high_q <= data_byte;
			end
			if (last) begin
				crc_q  <= '0;
				pos_q  <= '0;
				temp_q <= temp_next;
			end else begin
				crc_q <= crc_next;
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end
endmodule

@@ sv/scratchpad_crc_temperature_check.sv @@
// ----------------------------------------------------------------------------
// Scratchpad CRC temperature check
// Checks sensor scratchpad frames with CRC-8 and tracks the temperature.
// ----------------------------------------------------------------------------
// Scratchpad bytes arrive one per request on the scratch channel, byte 0 of
// each frame first, and go through the reflected CRC-8 of x^8+x^5+x^4+1.
// After FRAME_BYTES bytes the block issues one request on the result channel
// with the CRC remainder, a flag that is set when the remainder is zero, and
// the held temperature: on a good frame it becomes the raw 16-bit word of
// bytes 0 and 1 shifted right by four (negative readings become large
// values), on a bad frame the previous value stays. A byte is taken every
// cycle while the scratch channel does not stall: it lands in an input
// register, from there the CRC is updated with one byte-wide step, and a
// frame's last byte loads the result register that drives the result channel.
// Bytes keep flowing while a result waits to be taken; only a frame's last
// byte waits for the result register to be free, so the scratch channel
// stalls only when the result channel holds back a previous result.
module scratchpad_crc_temperature_check #(
	parameter int FRAME_BYTES = 9
) (
	input logic          clk,
	input logic          arst_n,
	sctc_byte_if.sink    scratch,
	sctc_result_if.source result
);
	import sctc_pkg::*;

	`include "scratchpad_crc_temperature_check_assert.svh"

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	sctc_res_t         res_s2;

	sctc_core_out_t core_status;
	logic           out_free;
	logic           fire;
	logic           in_accept;

	// The result register is free when it is empty or being drained now.
	assign out_free  = !valid_s2 || result.ready;
	// A byte may retire unless it closes a frame and the result slot is busy.
	assign fire      = valid_s1 && (!core_status.last || out_free);
	assign scratch.ready = !valid_s1 || fire;
	assign in_accept = scratch.valid && scratch.ready;

	sctc_frame_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.status    (core_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scratch.ready) begin
			valid_s1 <= scratch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= scratch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && core_status.last) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && core_status.last) begin
			res_s2 <= core_status.res;
		end
	end

	assign result.valid         = valid_s2;
	assign result.temperature   = res_s2.temperature;
	assign result.crc_ok        = res_s2.crc_ok;
	assign result.crc_remainder = res_s2.crc_remainder;

	// A frame-closing byte never retires while an untaken result is pending.
	`SCTC_ASSERT_NOW(a_no_overwrite, clk, arst_n, valid_s2 && !result.ready && core_status.last, !fire)
	// Closing a frame always leaves a result waiting in the next cycle.
	`SCTC_ASSERT_NEXT(a_result_follows, clk, arst_n, fire && core_status.last, valid_s2)
	// The good-CRC flag agrees with the reported remainder.
	`SCTC_ASSERT_NOW(a_ok_matches, clk, arst_n, valid_s2 && res_s2.crc_ok, res_s2.crc_remainder == '0)
endmodule
